### hdl/dsw_pkg.sv
package dsw_pkg;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_DROP   = 2'd1;
   localparam logic [1:0] REQ_TICKLE = 2'd2;

   localparam logic [2:0] REG_WAVE_SPEED_SQ   = 3'd0;
   localparam logic [2:0] REG_VERT_DAMPING    = 3'd1;
   localparam logic [2:0] REG_TIME_STEP       = 3'd2;
   localparam logic [2:0] REG_HORIZ_STIFFNESS = 3'd3;
   localparam logic [2:0] REG_HORIZ_DAMPING   = 3'd4;
   localparam logic [2:0] REG_SMALL_THR       = 3'd5;
   localparam logic [2:0] REG_VSMALL_THR      = 3'd6;

   localparam logic [15:0] RST_WAVE_SPEED_SQ   = 16'd410;
   localparam logic [15:0] RST_VERT_DAMPING    = 16'd410;
   localparam logic [15:0] RST_TIME_STEP       = 16'd410;
   localparam logic [15:0] RST_HORIZ_STIFFNESS = 16'd410;
   localparam logic [15:0] RST_HORIZ_DAMPING   = 16'd82;
   localparam logic [30:0] RST_SMALL_THR       = 31'd196608;
   localparam logic [30:0] RST_VSMALL_THR      = 31'd32768;

   typedef struct packed {
      logic calc1;
      logic calc2;
      logic calc3;
      logic commit;
      logic square;
      logic energy;
      logic flag;
      logic rotate;
   } step_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

### hdl/damped_string_wave_step_unit.sv
// Damped string wave step unit. A request with tuser 1 (drop) sets one cell's position and
// tuser 2 (tickle) sets the oscillator position; each returns nothing, and tuser 3 is
// dropped. A tick request (tuser 0) runs every cell's update in parallel in its own cell,
// with the oscillator alongside, in the steps of three calculation stages, a commit, then
// squaring, energy and threshold compare, and then streams NUM_CELLS results by rotating
// the cell row one step per accepted result. No request is taken until the tick's last
// result is out.
module damped_string_wave_step_unit #(
   parameter int NUM_CELLS = 21
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // cell_select[4:0], set_value[36:5], zero[39:37]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // cell_index[4:0], cell_position[36:5],
                                    // horiz_position[68:37], horiz_small[69],
                                    // horiz_very_small[70], zero[71]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = $clog2(NUM_CELLS);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CALC1 = 4'd1;
   localparam logic [3:0] ST_CALC2 = 4'd2;
   localparam logic [3:0] ST_CALC3 = 4'd3;
   localparam logic [3:0] ST_COMMIT = 4'd4;
   localparam logic [3:0] ST_SQUARE = 4'd5;
   localparam logic [3:0] ST_ENERGY = 4'd6;
   localparam logic [3:0] ST_FLAG  = 4'd7;
   localparam logic [3:0] ST_SEND  = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [15:0] wave_speed_sq_ff, vert_damping_ff, time_step_ff;
   logic [15:0] horiz_stiffness_ff, horiz_damping_ff;
   logic [30:0] small_thr_ff, vsmall_thr_ff;

   dsw_pkg::step_ctl_type ctl;

   logic               req_accept, rsp_accept, csr_write, is_last;
   logic               drop_req, tickle_req, tick_req;
   logic [4:0]         req_cell_select;
   logic signed [31:0] req_set_value;
   logic [2:0]         csr_index;

   logic signed [31:0] cell_pos [NUM_CELLS];
   logic signed [31:0] cell_vel [NUM_CELLS];
   logic [NUM_CELLS-1:0] drop_en;

   logic signed [31:0] horiz_position;
   logic               horiz_small, horiz_very_small;
   logic [31:0]        idx_wide;

   assign req_cell_select = req_tdata[4:0];
   assign req_set_value   = $signed(req_tdata[36:5]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign is_last    = (cnt_ff == IDX_W'(NUM_CELLS - 1));

   assign drop_req   = req_accept && (req_tuser == dsw_pkg::REQ_DROP);
   assign tickle_req = req_accept && (req_tuser == dsw_pkg::REQ_TICKLE);
   assign tick_req   = req_accept && (req_tuser == dsw_pkg::REQ_TICK);

   always_comb begin
      ctl        = '0;
      ctl.calc1  = (state_ff == ST_CALC1);
      ctl.calc2  = (state_ff == ST_CALC2);
      ctl.calc3  = (state_ff == ST_CALC3);
      ctl.commit = (state_ff == ST_COMMIT);
      ctl.square = (state_ff == ST_SQUARE);
      ctl.energy = (state_ff == ST_ENERGY);
      ctl.flag   = (state_ff == ST_FLAG);
      ctl.rotate = rsp_accept;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tick_req) begin
               state_in = ST_CALC1;
            end
         end
         ST_CALC1:  state_in = ST_CALC2;
         ST_CALC2:  state_in = ST_CALC3;
         ST_CALC3:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ENERGY;
         ST_ENERGY: state_in = ST_FLAG;
         ST_FLAG: begin
            state_in     = ST_SEND;
            cnt_in       = '0;
            rsp_valid_in = 1'b1;
         end
         ST_SEND: begin
            if (rsp_accept) begin
               if (is_last) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_speed_sq_ff   <= dsw_pkg::RST_WAVE_SPEED_SQ;
         vert_damping_ff    <= dsw_pkg::RST_VERT_DAMPING;
         time_step_ff       <= dsw_pkg::RST_TIME_STEP;
         horiz_stiffness_ff <= dsw_pkg::RST_HORIZ_STIFFNESS;
         horiz_damping_ff   <= dsw_pkg::RST_HORIZ_DAMPING;
         small_thr_ff       <= dsw_pkg::RST_SMALL_THR;
         vsmall_thr_ff      <= dsw_pkg::RST_VSMALL_THR;
      end else if (csr_write) begin
         case (csr_index)
            dsw_pkg::REG_WAVE_SPEED_SQ:   wave_speed_sq_ff   <= csr_pwdata[15:0];
            dsw_pkg::REG_VERT_DAMPING:    vert_damping_ff    <= csr_pwdata[15:0];
            dsw_pkg::REG_TIME_STEP:       time_step_ff       <= csr_pwdata[15:0];
            dsw_pkg::REG_HORIZ_STIFFNESS: horiz_stiffness_ff <= csr_pwdata[15:0];
            dsw_pkg::REG_HORIZ_DAMPING:   horiz_damping_ff   <= csr_pwdata[15:0];
            dsw_pkg::REG_SMALL_THR:       small_thr_ff       <= csr_pwdata[30:0];
            dsw_pkg::REG_VSMALL_THR:      vsmall_thr_ff      <= csr_pwdata[30:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         dsw_pkg::REG_WAVE_SPEED_SQ:   csr_prdata = 32'(wave_speed_sq_ff);
         dsw_pkg::REG_VERT_DAMPING:    csr_prdata = 32'(vert_damping_ff);
         dsw_pkg::REG_TIME_STEP:       csr_prdata = 32'(time_step_ff);
         dsw_pkg::REG_HORIZ_STIFFNESS: csr_prdata = 32'(horiz_stiffness_ff);
         dsw_pkg::REG_HORIZ_DAMPING:   csr_prdata = 32'(horiz_damping_ff);
         dsw_pkg::REG_SMALL_THR:       csr_prdata = 32'(small_thr_ff);
         dsw_pkg::REG_VSMALL_THR:      csr_prdata = 32'(vsmall_thr_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      assign drop_en[g] = drop_req && (32'(req_cell_select) == g);

      dsw_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .is_end        (1'((g == 0) || (g == NUM_CELLS - 1))),
         .wave_speed_sq (wave_speed_sq_ff),
         .vert_damping  (vert_damping_ff),
         .time_step     (time_step_ff),
         .prev_pos      (cell_pos[(g + NUM_CELLS - 1) % NUM_CELLS]),
         .next_pos      (cell_pos[(g + 1) % NUM_CELLS]),
         .next_vel      (cell_vel[(g + 1) % NUM_CELLS]),
         .drop_en       (drop_en[g]),
         .drop_value    (req_set_value),
         .pos           (cell_pos[g]),
         .vel           (cell_vel[g])
      );
   end

   dsw_osc u_osc (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .time_step            (time_step_ff),
      .horiz_stiffness      (horiz_stiffness_ff),
      .horiz_damping        (horiz_damping_ff),
      .small_threshold      (small_thr_ff),
      .very_small_threshold (vsmall_thr_ff),
      .tickle_en            (tickle_req),
      .tickle_value         (req_set_value),
      .horiz_position       (horiz_position),
      .horiz_small          (horiz_small),
      .horiz_very_small     (horiz_very_small)
   );

   assign idx_wide   = 32'(cnt_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = is_last;
   assign rsp_tdata  = {1'b0, horiz_very_small, horiz_small, horiz_position,
                        cell_pos[0], idx_wide[4:0]};

   a_valid_in_send: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == ST_SEND))
      else $error("result valid outside send phase");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while results pending");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("tick did not end after last result");

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == dsw_pkg::REQ_TICK)) |=>
      (state_ff == ST_CALC1))
      else $error("tick request did not start update");

endmodule

### hdl/dsw_cell.sv
module dsw_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  dsw_pkg::step_ctl_type ctl,
   input  logic                 is_end,
   input  logic [15:0]          wave_speed_sq,
   input  logic [15:0]          vert_damping,
   input  logic [15:0]          time_step,
   input  logic signed [31:0]   prev_pos,
   input  logic signed [31:0]   next_pos,
   input  logic signed [31:0]   next_vel,
   input  logic                 drop_en,
   input  logic signed [31:0]   drop_value,
   output logic signed [31:0]   pos,
   output logic signed [31:0]   vel
);

   logic signed [31:0] pos_ff, pos_in;
   logic signed [31:0] vel_ff, vel_in;
   logic signed [50:0] m_lap_ff, m_lap_in;
   logic signed [48:0] m_vd_ff, m_vd_in;
   logic signed [48:0] m_tv_ff, m_tv_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] np_ff, np_in;
   logic signed [48:0] m_ta_ff, m_ta_in;

   logic signed [16:0] ws_s, vd_s, ts_s;
   logic signed [33:0] lap;
   logic signed [51:0] diff;
   logic signed [51:0] diff_sh;

   assign ws_s = $signed({1'b0, wave_speed_sq});
   assign vd_s = $signed({1'b0, vert_damping});
   assign ts_s = $signed({1'b0, time_step});

   always_comb begin
      lap      = 34'(next_pos) + 34'(prev_pos) - (34'(pos_ff) <<< 1);
      m_lap_in = 51'(ws_s) * 51'(lap);
      m_vd_in  = 49'(vd_s) * 49'(vel_ff);
      m_tv_in  = 49'(ts_s) * 49'(vel_ff);
      diff     = 52'(m_lap_ff) - 52'(m_vd_ff);
      diff_sh  = diff >>> 12;
      acc_in   = dsw_pkg::sat32(64'(diff_sh));
      np_in    = dsw_pkg::sat32(64'(pos_ff) + 64'(m_tv_ff >>> 12));
      m_ta_in  = 49'(ts_s) * 49'(acc_ff);
      pos_in   = pos_ff;
      vel_in   = vel_ff;
      if (drop_en) begin
         pos_in = drop_value;
      end else if (ctl.commit) begin
         pos_in = np_ff;
         vel_in = is_end ? 32'sd0 : dsw_pkg::sat32(64'(vel_ff) + 64'(m_ta_ff >>> 12));
      end else if (ctl.rotate) begin
         pos_in = next_pos;
         vel_in = next_vel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         vel_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         vel_ff <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.calc1) begin
         m_lap_ff <= m_lap_in;
         m_vd_ff  <= m_vd_in;
         m_tv_ff  <= m_tv_in;
      end
      if (ctl.calc2) begin
         acc_ff <= acc_in;
         np_ff  <= np_in;
      end
      if (ctl.calc3) begin
         m_ta_ff <= m_ta_in;
      end
   end

   assign pos = pos_ff;
   assign vel = vel_ff;

endmodule

### hdl/dsw_osc.sv
module dsw_osc (
   input  logic                  clock,
   input  logic                  reset,
   input  dsw_pkg::step_ctl_type ctl,
   input  logic [15:0]           time_step,
   input  logic [15:0]           horiz_stiffness,
   input  logic [15:0]           horiz_damping,
   input  logic [30:0]           small_threshold,
   input  logic [30:0]           very_small_threshold,
   input  logic                  tickle_en,
   input  logic signed [31:0]    tickle_value,
   output logic signed [31:0]    horiz_position,
   output logic                  horiz_small,
   output logic                  horiz_very_small
);

   logic signed [31:0] h_ff, h_in;
   logic signed [31:0] hv_ff, hv_in;
   logic signed [48:0] m_hs_ff, m_hs_in;
   logic signed [48:0] m_hd_ff, m_hd_in;
   logic signed [48:0] m_ht_ff, m_ht_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] nh_ff, nh_in;
   logic signed [48:0] m_ha_ff, m_ha_in;
   logic [46:0]        hsq_ff, hsq_in;
   logic [46:0]        vsq_ff, vsq_in;
   logic [51:0]        energy_ff, energy_in;
   logic               small_ff, small_in;
   logic               vsmall_ff, vsmall_in;

   logic signed [16:0] ts_s, hs_s, hd_s;
   logic signed [49:0] diff;
   logic signed [49:0] diff_sh;
   logic signed [63:0] hh;
   logic signed [63:0] vv;
   logic [62:0]        e_mul;

   assign ts_s = $signed({1'b0, time_step});
   assign hs_s = $signed({1'b0, horiz_stiffness});
   assign hd_s = $signed({1'b0, horiz_damping});

   always_comb begin
      m_hs_in   = 49'(hs_s) * 49'(h_ff);
      m_hd_in   = 49'(hd_s) * 49'(hv_ff);
      m_ht_in   = 49'(ts_s) * 49'(hv_ff);
      diff      = -(50'(m_hs_ff)) - 50'(m_hd_ff);
      diff_sh   = diff >>> 12;
      acc_in    = dsw_pkg::sat32(64'(diff_sh));
      nh_in     = dsw_pkg::sat32(64'(h_ff) + 64'(m_ht_ff >>> 12));
      m_ha_in   = 49'(ts_s) * 49'(acc_ff);
      hh        = 64'(h_ff) * 64'(h_ff);
      vv        = 64'(hv_ff) * 64'(hv_ff);
      hsq_in    = hh[62:16];
      vsq_in    = vv[62:16];
      e_mul     = 63'(horiz_stiffness) * 63'(hsq_ff);
      energy_in = 52'(e_mul[62:12]) + 52'(vsq_ff);
      small_in  = energy_ff < 52'(small_threshold);
      vsmall_in = energy_ff < 52'(very_small_threshold);
      h_in      = h_ff;
      hv_in     = hv_ff;
      if (tickle_en) begin
         h_in = tickle_value;
      end else if (ctl.commit) begin
         h_in  = nh_ff;
         hv_in = dsw_pkg::sat32(64'(hv_ff) + 64'(m_ha_ff >>> 12));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff  <= '0;
         hv_ff <= '0;
      end else begin
         h_ff  <= h_in;
         hv_ff <= hv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.calc1) begin
         m_hs_ff <= m_hs_in;
         m_hd_ff <= m_hd_in;
         m_ht_ff <= m_ht_in;
      end
      if (ctl.calc2) begin
         acc_ff <= acc_in;
         nh_ff  <= nh_in;
      end
      if (ctl.calc3) begin
         m_ha_ff <= m_ha_in;
      end
      if (ctl.square) begin
         hsq_ff <= hsq_in;
         vsq_ff <= vsq_in;
      end
      if (ctl.energy) begin
         energy_ff <= energy_in;
      end
      if (ctl.flag) begin
         small_ff  <= small_in;
         vsmall_ff <= vsmall_in;
      end
   end

   assign horiz_position   = h_ff;
   assign horiz_small      = small_ff;
   assign horiz_very_small = vsmall_ff;

endmodule

### verif/damped_string_wave_step_unit_tb.sv
module damped_string_wave_step_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CELLS = 21;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [2:0] REG_UNMAPPED = 3'd7;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [4:0]         cell_index;
      logic signed [31:0] cell_position;
      logic               last_cell;
      logic signed [31:0] horiz_position;
      logic               horiz_small;
      logic               horiz_very_small;
   } cell_report_type;

   class string_wave_tracker;
      logic [15:0] wave_speed_sq;
      logic [15:0] vert_damping;
      logic [15:0] time_step;
      logic [15:0] horiz_stiffness;
      logic [15:0] horiz_damping;
      logic [30:0] small_thr;
      logic [30:0] vsmall_thr;
      int pos[NUM_CELLS];
      int vel[NUM_CELLS];
      int h;
      int hv;
      cell_report_type pending_cells[$];
      int mismatches;

      function new();
         wave_speed_sq = dsw_pkg::RST_WAVE_SPEED_SQ;
         vert_damping = dsw_pkg::RST_VERT_DAMPING;
         time_step = dsw_pkg::RST_TIME_STEP;
         horiz_stiffness = dsw_pkg::RST_HORIZ_STIFFNESS;
         horiz_damping = dsw_pkg::RST_HORIZ_DAMPING;
         small_thr = dsw_pkg::RST_SMALL_THR;
         vsmall_thr = dsw_pkg::RST_VSMALL_THR;
         foreach (pos[i]) begin
            pos[i] = 0;
            vel[i] = 0;
         end
         h = 0;
         hv = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            dsw_pkg::REG_WAVE_SPEED_SQ:   wave_speed_sq = value[15:0];
            dsw_pkg::REG_VERT_DAMPING:    vert_damping = value[15:0];
            dsw_pkg::REG_TIME_STEP:       time_step = value[15:0];
            dsw_pkg::REG_HORIZ_STIFFNESS: horiz_stiffness = value[15:0];
            dsw_pkg::REG_HORIZ_DAMPING:   horiz_damping = value[15:0];
            dsw_pkg::REG_SMALL_THR:       small_thr = value[30:0];
            dsw_pkg::REG_VSMALL_THR:      vsmall_thr = value[30:0];
            default: ;
         endcase
      endfunction

      function int clamp32(longint x);
         if (x > Q_MAX) return int'(Q_MAX);
         if (x < Q_MIN) return int'(Q_MIN);
         return int'(x);
      endfunction

      function longint scale_q412(logic [15:0] coef, longint v);
         longint c;
         c = coef;
         return (c * v) >>> 12;
      endfunction

      function void note_request(logic [1:0] kind, logic [4:0] sel, logic signed [31:0] value);
         int np[NUM_CELLS];
         int nv[NUM_CELLS];
         int nh, nhv;
         longint lap, acc, ws, vd, hs, hd, hsq, vsq, energy, thr_s, thr_vs;
         cell_report_type rep;
         case (kind)
            dsw_pkg::REQ_DROP: begin
               if (sel < NUM_CELLS) pos[sel] = value;
            end
            dsw_pkg::REQ_TICKLE: h = value;
            dsw_pkg::REQ_TICK: begin
               ws = wave_speed_sq;
               vd = vert_damping;
               hs = horiz_stiffness;
               hd = horiz_damping;
               for (int i = 0; i < NUM_CELLS; i++) begin
                  if (i == 0 || i == NUM_CELLS - 1) begin
                     nv[i] = 0;
                  end else begin
                     lap = longint'(pos[i+1]) + longint'(pos[i-1]) - 2 * longint'(pos[i]);
                     acc = clamp32((ws * lap - vd * longint'(vel[i])) >>> 12);
                     nv[i] = clamp32(longint'(vel[i]) + scale_q412(time_step, acc));
                  end
                  np[i] = clamp32(longint'(pos[i]) + scale_q412(time_step, vel[i]));
               end
               pos = np;
               vel = nv;
               acc = clamp32((-(hs * longint'(h)) - hd * longint'(hv)) >>> 12);
               nhv = clamp32(longint'(hv) + scale_q412(time_step, acc));
               nh = clamp32(longint'(h) + scale_q412(time_step, hv));
               hv = nhv;
               h = nh;
               hsq = (longint'(h) * longint'(h)) >>> 16;
               vsq = (longint'(hv) * longint'(hv)) >>> 16;
               energy = scale_q412(horiz_stiffness, hsq) + vsq;
               thr_s = small_thr;
               thr_vs = vsmall_thr;
               for (int i = 0; i < NUM_CELLS; i++) begin
                  rep.cell_index = i[4:0];
                  rep.cell_position = pos[i];
                  rep.last_cell = (i == NUM_CELLS - 1);
                  rep.horiz_position = h;
                  rep.horiz_small = (energy < thr_s);
                  rep.horiz_very_small = (energy < thr_vs);
                  pending_cells.push_back(rep);
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string field, longint expected, longint actual);
         if (expected != actual) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", field, expected, actual);
         end
      endfunction

      function void check_cell_report(cell_report_type got);
         cell_report_type exp;
         if (pending_cells.size() == 0) begin
            mismatches++;
            $error("result with no request pending: cell_index %0d", got.cell_index);
            return;
         end
         exp = pending_cells.pop_front();
         compare_field("cell_index", exp.cell_index, got.cell_index);
         compare_field("cell_position", exp.cell_position, got.cell_position);
         compare_field("last_cell", exp.last_cell, got.last_cell);
         compare_field("horiz_position", exp.horiz_position, got.horiz_position);
         compare_field("horiz_small", exp.horiz_small, got.horiz_small);
         compare_field("horiz_very_small", exp.horiz_very_small, got.horiz_very_small);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // cell_select[4:0], set_value[36:5], zero[39:37]
   logic [1:0]  req_tuser = '0;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // cell_index[4:0], cell_position[36:5],
                                  // horiz_position[68:37], horiz_small[69],
                                  // horiz_very_small[70], zero[71]
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   string_wave_tracker sb = new();
   cell_report_type rsp_seen;
   int  cycle_count = 0;
   int  hold_seq = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   bit  steady = 1'b0;

   damped_string_wave_step_unit #(
      .NUM_CELLS(NUM_CELLS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** damped_string_wave_step_unit: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen.cell_index = rsp_tdata[4:0];
         rsp_seen.cell_position = $signed(rsp_tdata[36:5]);
         rsp_seen.last_cell = rsp_tlast;
         rsp_seen.horiz_position = $signed(rsp_tdata[68:37]);
         rsp_seen.horiz_small = rsp_tdata[69];
         rsp_seen.horiz_very_small = rsp_tdata[70];
         sb.check_cell_report(rsp_seen);
      end
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 12);
      end
   end

   function automatic logic signed [31:0] q16_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 524288) - 262144;
      if (r < 75) return $urandom_range(0, 32767) - 16384;
      if (r < 90) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sh00000000;
         default: return 32'shffffffff;
      endcase
   endfunction

   task automatic send_request(logic [1:0] kind, logic [4:0] sel, logic signed [31:0] value);
      if (!steady && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {3'b000, value, sel};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, sel, value);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_cells.size() != 0);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(logic [31:0] vals[7]);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 7; i++) write_csr(i[2:0], vals[i]);
      write_csr(REG_UNMAPPED, $urandom);
   endtask

   task automatic run_random(int count, bit pause_midway);
      int unsigned r;
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) wait_drained();
         r = $urandom_range(0, 99);
         if (r < 44)
            send_request(dsw_pkg::REQ_TICK, 5'($urandom_range(0, 31)), q16_value());
         else if (r < 72)
            send_request(dsw_pkg::REQ_DROP, 5'($urandom_range(0, NUM_CELLS - 1)),
                         q16_value());
         else if (r < 76)
            send_request(dsw_pkg::REQ_DROP, 5'($urandom_range(NUM_CELLS, 31)), q16_value());
         else if (r < 90)
            send_request(dsw_pkg::REQ_TICKLE, 5'($urandom_range(0, 31)), q16_value());
         else
            send_request(REQ_UNUSED, 5'($urandom_range(0, 31)), q16_value());
      end
   endtask

   initial begin
      logic [31:0] vals[7];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(dsw_pkg::REQ_TICK, 5'd0, 32'sh0);
      send_request(dsw_pkg::REQ_DROP, 5'd0, 32'sh7fffffff);
      send_request(dsw_pkg::REQ_DROP, 5'd20, 32'sh80000000);
      send_request(dsw_pkg::REQ_DROP, 5'd10, 32'sh00010000);
      send_request(dsw_pkg::REQ_DROP, 5'd9, 32'shffffffff);
      send_request(dsw_pkg::REQ_DROP, 5'd21, 32'sh000004d2);
      send_request(dsw_pkg::REQ_DROP, 5'd31, 32'sh7fffffff);
      send_request(dsw_pkg::REQ_TICKLE, 5'd31, 32'sh7fffffff);
      send_request(dsw_pkg::REQ_TICK, 5'd0, 32'sh0);
      send_request(dsw_pkg::REQ_TICK, 5'd31, 32'shffffffff);
      send_request(REQ_UNUSED, 5'd31, 32'shffffffff);
      send_request(dsw_pkg::REQ_TICKLE, 5'd0, 32'sh80000000);
      send_request(dsw_pkg::REQ_TICK, 5'd0, 32'sh0);
      send_request(dsw_pkg::REQ_TICKLE, 5'd0, 32'sh00020000);
      send_request(dsw_pkg::REQ_TICK, 5'd0, 32'sh0);
      send_request(dsw_pkg::REQ_TICK, 5'd0, 32'sh0);
      send_request(dsw_pkg::REQ_DROP, 5'd1, 32'sh7fffffff);
      send_request(dsw_pkg::REQ_DROP, 5'd2, 32'sh80000000);
      send_request(dsw_pkg::REQ_DROP, 5'd3, 32'sh7fffffff);
      send_request(dsw_pkg::REQ_TICK, 5'd0, 32'sh0);
      send_request(dsw_pkg::REQ_TICK, 5'd0, 32'sh0);

      run_random(64, 1'b1);

      vals = '{default: 32'h0};
      load_config(vals);
      hold_seq++;
      run_random(64, 1'b0);

      vals = '{default: 32'hffffffff};
      load_config(vals);
      run_random(64, 1'b0);

      for (int i = 0; i < 5; i++) vals[i] = $urandom_range(0, 8191);
      vals[5] = $urandom_range(0, 1 << 20);
      vals[6] = $urandom_range(0, 1 << 17);
      load_config(vals);
      steady = 1'b1;
      run_random(64, 1'b0);
      steady = 1'b0;

      for (int i = 0; i < 7; i++) vals[i] = $urandom;
      load_config(vals);
      run_random(32, 1'b0);

      vals = '{32'd410, 32'd410, 32'd410, 32'd410, 32'd82, 32'd0, 32'd0};
      vals[5] = $urandom_range(0, 1 << 19);
      vals[6] = $urandom_range(0, 1 << 16);
      load_config(vals);
      run_random(32, 1'b1);

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_cells.size() == 0) begin
         $display("** damped_string_wave_step_unit: PASSED **");
      end else begin
         $display("** damped_string_wave_step_unit: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
hdl/dsw_pkg.sv
hdl/dsw_cell.sv
hdl/dsw_osc.sv
hdl/damped_string_wave_step_unit.sv
verif/damped_string_wave_step_unit_tb.sv
